[rtl/msu_pkg.sv]
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types and constants of the momentum stencil update pipeline.
// ----------------------------------------------------------------------------
package msu_pkg;

    localparam int FLD_W     = 32;   // Q16.16 field width
    localparam int COEF_W    = 32;   // Q8.24 coefficient width
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 112;  // exact accumulator, 64 fraction bits
    localparam int CONV_W    = 104;  // coefficient-scaled sums: conv 56, visc 64 fraction bits

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DT_OVER_DX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DT_OVER_DY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DT_OVER_DX_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT_OVER_DY_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY     = 3'd4;

    // Component select
    localparam logic CMD_U = 1'b0;
    localparam logic CMD_V = 1'b1;

    // Alignment shifts to 64 fraction bits (0.25 folds into the convective shift)
    localparam int CONV_ALIGN  = 6;
    localparam int PRESS_ALIGN = 24;
    localparam int CENTER_ALIGN = 48;
    localparam int OUT_SHIFT   = 48;
    localparam logic [ACC_W-1:0] RND_BIAS = {{(ACC_W-1){1'b0}}, 1'b1} << 47;

    localparam logic [FLD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [FLD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [COEF_W-1:0] dt_over_dx;
        logic [COEF_W-1:0] dt_over_dy;
        logic [COEF_W-1:0] dt_over_dx_sq;
        logic [COEF_W-1:0] dt_over_dy_sq;
        logic [COEF_W-1:0] viscosity;
    } t_coef;

    // Front end result: raw stencil products, Q32.32 / Q16.40 / Q16.40 scale
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] c;
        logic signed [66:0] d_al;
        logic signed [66:0] d_ac;
        logic signed [67:0] lap;
        logic signed [65:0] press;
    } t_front;

    // Scaled terms, ready for final accumulation
    typedef struct packed {
        logic signed [31:0]       c;
        logic signed [65:0]       press;
        logic signed [CONV_W-1:0] conv;
        logic signed [CONV_W-1:0] visc;
    } t_scaled;

endpackage

[rtl/msu_cfg_regs.sv]
// ----------------------------------------------------------------------------
// msu_cfg_regs
// Coefficient register file written through the configuration channel.
// ----------------------------------------------------------------------------
module msu_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msu_pkg::COEF_W-1:0]     i_cfg_data,
    output msu_pkg::t_coef                 o_coef
);
    import msu_pkg::*;

    t_coef r_coef;
    t_coef n_coef;

    assign o_cfg_ready = 1'b1;
    assign o_coef      = r_coef;

    always_comb begin
        n_coef = r_coef;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DT_OVER_DX:    n_coef.dt_over_dx    = i_cfg_data;
                REG_DT_OVER_DY:    n_coef.dt_over_dy    = i_cfg_data;
                REG_DT_OVER_DX_SQ: n_coef.dt_over_dx_sq = i_cfg_data;
                REG_DT_OVER_DY_SQ: n_coef.dt_over_dy_sq = i_cfg_data;
                REG_VISCOSITY:     n_coef.viscosity     = i_cfg_data;
                default:           n_coef = r_coef;  // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else begin
            r_coef <= n_coef;
        end
    end

    a_visc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_VISCOSITY)
            |=> (r_coef.viscosity == $past(i_cfg_data)))
        else $error("viscosity write not taken");

endmodule

[rtl/msu_front.sv]
// ----------------------------------------------------------------------------
// msu_front
// Stages 1-3: stencil sums, signed stencil products, product combination.
// ----------------------------------------------------------------------------
module msu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msu_pkg::t_coef     i_coef,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic signed [31:0] i_self_center,
    input  logic signed [31:0] i_self_along_plus,
    input  logic signed [31:0] i_self_along_minus,
    input  logic signed [31:0] i_self_across_plus,
    input  logic signed [31:0] i_self_across_minus,
    input  logic signed [31:0] i_other_center,
    input  logic signed [31:0] i_other_along_plus,
    input  logic signed [31:0] i_other_across_minus,
    input  logic signed [31:0] i_other_diagonal,
    input  logic signed [31:0] i_pressure_center,
    input  logic signed [31:0] i_pressure_along_plus,
    output logic               o_valid,
    input  logic               i_ready,
    output msu_pkg::t_front    o_data
);
    import msu_pkg::*;

    logic rdy1, rdy2, rdy3;
    logic r_v1, r_v2, r_v3;

    // stage 1: sums
    logic               r_s1_cmd;
    logic signed [31:0] r_s1_c;
    logic signed [32:0] r_s1_sa,  n_s1_sa;   // ap - am
    logic signed [33:0] r_s1_sb,  n_s1_sb;   // ap + 2c + am
    logic signed [32:0] r_s1_xpc, n_s1_xpc;  // xp + c
    logic signed [32:0] r_s1_oao, n_s1_oao;  // oap + oc
    logic signed [32:0] r_s1_cxm, n_s1_cxm;  // c + xm
    logic signed [32:0] r_s1_odx, n_s1_odx;  // od + oxm
    logic signed [32:0] r_s1_dp,  n_s1_dp;   // pap - pc
    logic signed [33:0] r_s1_lal, n_s1_lal;  // ap - 2c + am
    logic signed [33:0] r_s1_lac, n_s1_lac;  // xp - 2c + xm

    // stage 2: products
    logic               r_s2_cmd;
    logic signed [31:0] r_s2_c;
    logic signed [66:0] r_s2_pal, n_s2_pal;
    logic signed [65:0] r_s2_px1, n_s2_px1;
    logic signed [65:0] r_s2_px2, n_s2_px2;
    logic signed [65:0] r_s2_prs, n_s2_prs;
    logic signed [66:0] r_s2_val, n_s2_val;
    logic signed [66:0] r_s2_vac, n_s2_vac;
    logic [COEF_W-1:0]  k_al, s_al, s_ac;

    // stage 3
    t_front r_s3_data, n_s3_data;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_s3_data;

    always_comb begin
        n_s1_sa  = 33'(i_self_along_plus) - 33'(i_self_along_minus);
        n_s1_sb  = 34'(i_self_along_plus) + 34'(i_self_along_minus)
                 + 34'(i_self_center) + 34'(i_self_center);
        n_s1_xpc = 33'(i_self_across_plus) + 33'(i_self_center);
        n_s1_oao = 33'(i_other_along_plus) + 33'(i_other_center);
        n_s1_cxm = 33'(i_self_center) + 33'(i_self_across_minus);
        n_s1_odx = 33'(i_other_diagonal) + 33'(i_other_across_minus);
        n_s1_dp  = 33'(i_pressure_along_plus) - 33'(i_pressure_center);
        n_s1_lal = 34'(i_self_along_plus) + 34'(i_self_along_minus)
                 - 34'(i_self_center) - 34'(i_self_center);
        n_s1_lac = 34'(i_self_across_plus) + 34'(i_self_across_minus)
                 - 34'(i_self_center) - 34'(i_self_center);
    end

    // swap axes for the v component
    always_comb begin
        k_al = (r_s1_cmd == CMD_V) ? i_coef.dt_over_dy    : i_coef.dt_over_dx;
        s_al = (r_s1_cmd == CMD_V) ? i_coef.dt_over_dy_sq : i_coef.dt_over_dx_sq;
        s_ac = (r_s1_cmd == CMD_V) ? i_coef.dt_over_dx_sq : i_coef.dt_over_dy_sq;
        n_s2_pal = 67'(r_s1_sa) * 67'(r_s1_sb);
        n_s2_px1 = 66'(r_s1_xpc) * 66'(r_s1_oao);
        n_s2_px2 = 66'(r_s1_cxm) * 66'(r_s1_odx);
        n_s2_prs = 66'(r_s1_dp) * 66'($signed({1'b0, k_al}));
        n_s2_val = 67'(r_s1_lal) * 67'($signed({1'b0, s_al}));
        n_s2_vac = 67'(r_s1_lac) * 67'($signed({1'b0, s_ac}));
    end

    always_comb begin
        n_s3_data.cmd   = r_s2_cmd;
        n_s3_data.c     = r_s2_c;
        n_s3_data.d_al  = r_s2_pal;
        n_s3_data.d_ac  = 67'(r_s2_px1) - 67'(r_s2_px2);
        n_s3_data.lap   = 68'(r_s2_val) + 68'(r_s2_vac);
        n_s3_data.press = r_s2_prs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_cmd <= i_cmd;
            r_s1_c   <= i_self_center;
            r_s1_sa  <= n_s1_sa;
            r_s1_sb  <= n_s1_sb;
            r_s1_xpc <= n_s1_xpc;
            r_s1_oao <= n_s1_oao;
            r_s1_cxm <= n_s1_cxm;
            r_s1_odx <= n_s1_odx;
            r_s1_dp  <= n_s1_dp;
            r_s1_lal <= n_s1_lal;
            r_s1_lac <= n_s1_lac;
        end
        if (rdy2 && r_v1) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_c   <= r_s1_c;
            r_s2_pal <= n_s2_pal;
            r_s2_px1 <= n_s2_px1;
            r_s2_px2 <= n_s2_px2;
            r_s2_prs <= n_s2_prs;
            r_s2_val <= n_s2_val;
            r_s2_vac <= n_s2_vac;
        end
        if (rdy3 && r_v2) begin
            r_s3_data <= n_s3_data;
        end
    end

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted transaction did not enter stage 1");

endmodule

[rtl/msu_scale.sv]
// ----------------------------------------------------------------------------
// msu_scale
// Stages 4-5: scale wide products by 32-bit coefficients in two partial
// products each, then recombine.
// ----------------------------------------------------------------------------
module msu_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msu_pkg::t_coef   i_coef,
    input  logic             i_valid,
    output logic             o_ready,
    input  msu_pkg::t_front  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output msu_pkg::t_scaled o_data
);
    import msu_pkg::*;

    logic rdy4, rdy5;
    logic r_v4, r_v5;

    logic [COEF_W-1:0]  k_al, k_ac;

    logic signed [31:0] r_s4_c;
    logic signed [65:0] r_s4_prs;
    logic [63:0]        r_s4_lo_al, n_s4_lo_al;
    logic [63:0]        r_s4_lo_ac, n_s4_lo_ac;
    logic [63:0]        r_s4_lo_nu, n_s4_lo_nu;
    logic signed [67:0] r_s4_hi_al, n_s4_hi_al;
    logic signed [67:0] r_s4_hi_ac, n_s4_hi_ac;
    logic signed [68:0] r_s4_hi_nu, n_s4_hi_nu;

    t_scaled r_s5_data, n_s5_data;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;
    assign o_valid = r_v5;
    assign o_data  = r_s5_data;

    always_comb begin
        k_al = (i_data.cmd == CMD_V) ? i_coef.dt_over_dy : i_coef.dt_over_dx;
        k_ac = (i_data.cmd == CMD_V) ? i_coef.dt_over_dx : i_coef.dt_over_dy;
        n_s4_lo_al = 64'(i_data.d_al[31:0]) * 64'(k_al);
        n_s4_lo_ac = 64'(i_data.d_ac[31:0]) * 64'(k_ac);
        n_s4_lo_nu = 64'(i_data.lap[31:0]) * 64'(i_coef.viscosity);
        n_s4_hi_al = 68'($signed(i_data.d_al[66:32])) * 68'($signed({1'b0, k_al}));
        n_s4_hi_ac = 68'($signed(i_data.d_ac[66:32])) * 68'($signed({1'b0, k_ac}));
        n_s4_hi_nu = 69'($signed(i_data.lap[67:32]))
                   * 69'($signed({1'b0, i_coef.viscosity}));
    end

    always_comb begin
        logic signed [CONV_W-1:0] hs;
        logic signed [CONV_W-1:0] hv;
        hs = CONV_W'(r_s4_hi_al) + CONV_W'(r_s4_hi_ac);
        hv = CONV_W'(r_s4_hi_nu);
        n_s5_data.c     = r_s4_c;
        n_s5_data.press = r_s4_prs;
        n_s5_data.conv  = (hs <<< 32) + {40'd0, r_s4_lo_al} + {40'd0, r_s4_lo_ac};
        n_s5_data.visc  = (hv <<< 32) + {40'd0, r_s4_lo_nu};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_s4_c     <= i_data.c;
            r_s4_prs   <= i_data.press;
            r_s4_lo_al <= n_s4_lo_al;
            r_s4_lo_ac <= n_s4_lo_ac;
            r_s4_lo_nu <= n_s4_lo_nu;
            r_s4_hi_al <= n_s4_hi_al;
            r_s4_hi_ac <= n_s4_hi_ac;
            r_s4_hi_nu <= n_s4_hi_nu;
        end
        if (rdy5 && r_v4) begin
            r_s5_data <= n_s5_data;
        end
    end

    a_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !rdy5) |=> r_v4)
        else $error("stage 4 transaction dropped under stall");

endmodule

[rtl/msu_round.sv]
// ----------------------------------------------------------------------------
// msu_round
// Stages 6-7: accumulate all terms, round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
module msu_round (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  msu_pkg::t_scaled         i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [31:0]       o_new_velocity,
    output logic                     o_saturated
);
    import msu_pkg::*;

    logic rdy6, rdy7;
    logic r_v6, r_v7;

    logic signed [ACC_W-1:0] r_s6_a, n_s6_a;
    logic signed [ACC_W-1:0] r_s6_b, n_s6_b;

    logic [FLD_W-1:0] r_s7_vel, n_s7_vel;
    logic             r_s7_sat, n_s7_sat;

    assign rdy7           = !r_v7 || i_ready;
    assign rdy6           = !r_v6 || rdy7;
    assign o_ready        = rdy6;
    assign o_valid        = r_v7;
    assign o_new_velocity = $signed(r_s7_vel);
    assign o_saturated    = r_s7_sat;

    always_comb begin
        logic signed [ACC_W-1:0] cw;
        logic signed [ACC_W-1:0] pw;
        logic signed [ACC_W-1:0] convw;
        logic signed [ACC_W-1:0] viscw;
        cw     = ACC_W'(i_data.c);
        pw     = ACC_W'(i_data.press);
        convw  = ACC_W'(i_data.conv);
        viscw  = ACC_W'(i_data.visc);
        n_s6_a = (cw <<< CENTER_ALIGN) + $signed(RND_BIAS) - (pw <<< PRESS_ALIGN);
        n_s6_b = viscw - (convw <<< CONV_ALIGN);
    end

    always_comb begin
        logic [ACC_W-1:0] total;
        logic [32:0]      top;
        total = r_s6_a + r_s6_b;
        top   = total[ACC_W-1:OUT_SHIFT+FLD_W-1];
        // the rounded value fits when its sign bit and all bits above it agree
        n_s7_sat = !((&top) || (~|top));
        if (n_s7_sat) begin
            n_s7_vel = total[ACC_W-1] ? SAT_NEG : SAT_POS;
        end else begin
            n_s7_vel = total[OUT_SHIFT+FLD_W-1:OUT_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy6) r_v6 <= i_valid;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && i_valid) begin
            r_s6_a <= n_s6_a;
            r_s6_b <= n_s6_b;
        end
        if (rdy7 && r_v6) begin
            r_s7_vel <= n_s7_vel;
            r_s7_sat <= n_s7_sat;
        end
    end

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v7 && r_s7_sat) |-> (r_s7_vel == SAT_POS || r_s7_vel == SAT_NEG))
        else $error("saturation flag without clipped value");

    a_stage6_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !rdy7) |=> (r_v6 && $stable(r_s6_a) && $stable(r_s6_b)))
        else $error("stage 6 transaction changed under stall");

endmodule

[rtl/momentum_stencil_update_top.sv]
// ----------------------------------------------------------------------------
// momentum_stencil_update_top
// Explicit staggered-grid momentum update for one grid point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Coefficients (Q8.24) are written on the configuration channel
//   (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data); o_cfg_ready is
//   always high and indexes past the register list are dropped. Write them
//   only while no transaction is in flight.
//   Each input transaction (i_valid / o_ready) carries one stencil
//   neighborhood and i_cmd (0: u, 1: v). Each produces one output
//   transaction (o_valid / i_ready) with o_new_velocity and o_saturated.
//   The seven register stages are, in order: sums, stencil products,
//   product combine, coefficient partial products, recombine, accumulate,
//   round and saturate.
//   Throughput is one transaction per cycle while i_ready stays high.
//   When the receiver holds i_ready low, a stage with valid data holds once
//   every stage after it is full; empty stages still fill, so o_ready drops
//   only once the whole pipeline is full. Nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline and clears all
//   coefficients to zero.
// ----------------------------------------------------------------------------
module momentum_stencil_update_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [msu_pkg::COEF_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic signed [31:0]            i_self_center,
    input  logic signed [31:0]            i_self_along_plus,
    input  logic signed [31:0]            i_self_along_minus,
    input  logic signed [31:0]            i_self_across_plus,
    input  logic signed [31:0]            i_self_across_minus,
    input  logic signed [31:0]            i_other_center,
    input  logic signed [31:0]            i_other_along_plus,
    input  logic signed [31:0]            i_other_across_minus,
    input  logic signed [31:0]            i_other_diagonal,
    input  logic signed [31:0]            i_pressure_center,
    input  logic signed [31:0]            i_pressure_along_plus,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_new_velocity,
    output logic                          o_saturated
);
    import msu_pkg::*;

    t_coef   coef;
    t_front  front_data;
    t_scaled scaled_data;
    logic    front_valid, front_ready;
    logic    scaled_valid, scaled_ready;

    msu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    msu_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_coef                (coef),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_cmd                 (i_cmd),
        .i_self_center         (i_self_center),
        .i_self_along_plus     (i_self_along_plus),
        .i_self_along_minus    (i_self_along_minus),
        .i_self_across_plus    (i_self_across_plus),
        .i_self_across_minus   (i_self_across_minus),
        .i_other_center        (i_other_center),
        .i_other_along_plus    (i_other_along_plus),
        .i_other_across_minus  (i_other_across_minus),
        .i_other_diagonal      (i_other_diagonal),
        .i_pressure_center     (i_pressure_center),
        .i_pressure_along_plus (i_pressure_along_plus),
        .o_valid               (front_valid),
        .i_ready               (front_ready),
        .o_data                (front_data)
    );

    msu_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (scaled_valid),
        .i_ready (scaled_ready),
        .o_data  (scaled_data)
    );

    msu_round u_round (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (scaled_valid),
        .o_ready        (scaled_ready),
        .i_data         (scaled_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_new_velocity (o_new_velocity),
        .o_saturated    (o_saturated)
    );

endmodule
